// ===== src/dq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types for the double-ended queue: operation and status codes and
// the per-cell control word.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned FuncWidth   = 2;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned ValueWidth  = 32;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_REAR  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_REAR   = 2'd3
  } func_e;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic take_prev;
    logic take_next;
    logic take_push;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== src/dq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_cell
// One storage cell of the queue row. Takes the word of its front-side
// neighbor on a push at the front, of its rear-side neighbor on a pop at
// the front, or the pushed word when it is the slot past the rear.
// ----------------------------------------------------------------------------
module dq_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire dq_pkg::cell_ctrl_t     ctrl_i,
  input  wire logic [DATA_WIDTH-1:0]  prev_i,
  input  wire logic [DATA_WIDTH-1:0]  next_i,
  input  wire logic [DATA_WIDTH-1:0]  push_i,
  output logic      [DATA_WIDTH-1:0]  data_o
);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.take_prev) begin
      data_d = prev_i;
    end else if (ctrl_i.take_next) begin
      data_d = next_i;
    end else if (ctrl_i.take_push) begin
      data_d = push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ===== src/double_ended_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// The front entry always sits in cell 0 and the entries fill the row in
// order, so a push or pop at the front shifts the whole row by one cell,
// a rear push writes only the cell at the current fill level; a rear pop writes none.
// Every input word yields one output word with the popped value (zero when
// nothing was popped), a status and the occupancy after the operation. The
// result is registered and appears on the output in the cycle after its input
// word is taken. A word can be taken every clock cycle as long as the output
// word is taken in the same cycle; a result held back by m_axis_tready stalls
// the input until it leaves. A refused push or pop leaves the contents unchanged.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned OccWidth  = $clog2(DEPTH + 1),
  localparam int unsigned OutWidth  = ((dq_pkg::ValueWidth + OccWidth + 7) / 8) * 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [dq_pkg::ValueWidth-1:0]     s_axis_tdata,  // push_value
  input  wire logic [dq_pkg::FuncWidth-1:0]      s_axis_tuser,  // func
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [OutWidth-1:0]               m_axis_tdata,  // pop_value, occupancy
  output logic      [dq_pkg::StatusWidth-1:0]    m_axis_tuser   // status
);

  localparam int unsigned IdxWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PadWidth = OutWidth - dq_pkg::ValueWidth - OccWidth;

  dq_pkg::func_e      func;
  dq_pkg::status_e    status;
  dq_pkg::cell_ctrl_t ctrl [DEPTH];

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] push_word;
  logic [DATA_WIDTH-1:0] pop_word;
  logic [OccWidth-1:0]   count_q, count_d;
  logic [OccWidth-1:0]   rear_pos;
  logic [IdxWidth-1:0]   rear_idx;
  logic                  accept;
  logic                  is_full, is_empty, do_op;

  logic                          out_valid_q;
  logic [dq_pkg::ValueWidth-1:0] out_value_q, out_value_d;
  logic [OccWidth-1:0]           out_occ_q;
  dq_pkg::status_e               out_status_q;

  assign func          = dq_pkg::func_e'(s_axis_tuser);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  generate
    if (DATA_WIDTH > dq_pkg::ValueWidth) begin : g_wide
      assign push_word   = {{(DATA_WIDTH - dq_pkg::ValueWidth){1'b0}}, s_axis_tdata};
      assign out_value_d = pop_word[dq_pkg::ValueWidth-1:0];
    end else if (DATA_WIDTH == dq_pkg::ValueWidth) begin : g_equal
      assign push_word   = s_axis_tdata;
      assign out_value_d = pop_word;
    end else begin : g_narrow
      assign push_word   = s_axis_tdata[DATA_WIDTH-1:0];
      assign out_value_d = {{(dq_pkg::ValueWidth - DATA_WIDTH){1'b0}}, pop_word};
    end
  endgenerate

  assign is_full  = (count_q == OccWidth'(DEPTH));
  assign is_empty = (count_q == '0);
  assign rear_pos = count_q - OccWidth'(1);
  assign rear_idx = rear_pos[IdxWidth-1:0];

  always_comb begin
    status   = dq_pkg::STATUS_DONE;
    do_op    = 1'b0;
    pop_word = '0;
    count_d  = count_q;
    unique case (func)
      dq_pkg::FUNC_PUSH_FRONT, dq_pkg::FUNC_PUSH_REAR: begin
        if (is_full) begin
          status = dq_pkg::STATUS_FULL;
        end else begin
          do_op   = accept;
          count_d = count_q + OccWidth'(1);
        end
      end
      dq_pkg::FUNC_POP_FRONT: begin
        if (is_empty) begin
          status = dq_pkg::STATUS_EMPTY;
        end else begin
          do_op    = accept;
          pop_word = cell_data[0];
          count_d  = rear_pos;
        end
      end
      dq_pkg::FUNC_POP_REAR: begin
        if (is_empty) begin
          status = dq_pkg::STATUS_EMPTY;
        end else begin
          do_op    = accept;
          pop_word = cell_data[rear_idx];
          count_d  = rear_pos;
        end
      end
      default: begin
        status = dq_pkg::STATUS_DONE;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_word;
    logic [DATA_WIDTH-1:0] next_word;

    if (i == 0) begin : g_first
      assign prev_word = push_word;
    end else begin : g_prev
      assign prev_word = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_word = cell_data[i];
    end else begin : g_next
      assign next_word = cell_data[i+1];
    end

    assign ctrl[i].take_prev = do_op && (func == dq_pkg::FUNC_PUSH_FRONT);
    assign ctrl[i].take_next = do_op && (func == dq_pkg::FUNC_POP_FRONT);
    assign ctrl[i].take_push = do_op && (func == dq_pkg::FUNC_PUSH_REAR)
                               && (count_q == OccWidth'(i));

    dq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i (clk_i),
      .ctrl_i(ctrl[i]),
      .prev_i(prev_word),
      .next_i(next_word),
      .push_i(push_word),
      .data_o(cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_op) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q  <= out_value_d;
      out_status_q <= status;
      out_occ_q    <= do_op ? count_d : count_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PadWidth{1'b0}}, out_occ_q, out_value_q};
  assign m_axis_tuser  = out_status_q;

endmodule
`default_nettype wire
